>>> rtl/core/tld_pkg.sv
`default_nettype none
package tld_pkg;
   localparam int BufferDepth = 512;
   localparam logic [3:0]  InFlagsReset  = 4'd4;
   localparam logic [4:0]  LocFlagsReset = 5'd15;
   localparam logic [23:0] SigCharsReset = 24'h1A1C03;
   localparam logic [31:0] EditCharsReset = 32'h17157F04;
   localparam logic [15:0] EofMax = 16'hFFFF;

   localparam logic [1:0] ModeRx    = 2'd0;
   localparam logic [1:0] ModeRead  = 2'd1;
   localparam logic [1:0] ModeFlush = 2'd2;

   localparam logic [2:0] EchoNone  = 3'd0;
   localparam logic [2:0] EchoByte  = 3'd1;
   localparam logic [2:0] EchoCaret = 3'd2;
   localparam logic [2:0] EchoCrlf  = 3'd3;
   localparam logic [2:0] EchoErase = 3'd4;

   localparam logic [1:0] RegInFlags  = 2'd0;
   localparam logic [1:0] RegLocFlags = 2'd1;
   localparam logic [1:0] RegSigChars = 2'd2;
   localparam logic [1:0] RegEditChars = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_COMMIT_RD, ST_COMMIT_WR, ST_COMMIT_NL,
      ST_WERASE_RD, ST_WERASE_CHK, ST_READ_RD, ST_READ_DONE, ST_RESULT
   } state_type;

   typedef struct packed {
      logic [2:0] echo_kind;
      logic [7:0] echo_byte;
      logic [8:0] erase_count;
      logic [1:0] signal_kind;
      logic       wake;
      logic       flushed;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_eof;
      logic       line_done;
      logic [8:0] queue_count;
   } result_type;

   function automatic logic [2:0] echo_kind_of(input logic [7:0] c);
      if (c == 8'h0A || c == 8'h0D) return EchoCrlf;
      if (c == 8'h09) return EchoByte;
      if (c < 8'h20) return EchoCaret;
      if (c == 8'h7F) return EchoNone;
      return EchoByte;
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/tld_ram.sv
`default_nettype none
module tld_ram #(
   parameter int Depth = tld_pkg::BufferDepth,
   localparam int AW = $clog2(Depth)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic [AW-1:0] raddr,
   output logic [7:0]         rdata
);
   logic [7:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> rtl/core/tty_line_discipline.sv
// Receive: decide, result; read adds the queue read states; line commit reads and
// writes each stored byte; word erase reads and checks each examined byte. One item
// at a time. Throughput is set by the single read port of the line store during
// commit and word erase. Result is held in an output register until taken.
// Synchronous reset restores CSRs, clears pointers and EOF count; buffers not cleared.
`default_nettype none
module tty_line_discipline #(
   parameter int BUFFER_DEPTH = tld_pkg::BufferDepth,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // mode[1:0], in_byte[9:2], zeros
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // echo_kind[2:0], echo_byte[10:3], erase_count[19:11], signal_kind[21:20],
   // wake[22], flushed[23], read_valid[24], read_byte[32:25], read_eof[33],
   // line_done[34], queue_count[43:35], zeros
   output logic [47:0]      rsp_tdata
);
   localparam logic [AW-1:0] One = AW'(1);
   localparam logic [AW:0] LineMax = (AW+1)'(BUFFER_DEPTH - 1);

   logic [3:0]  in_flags_ff;
   logic [4:0]  loc_flags_ff;
   logic [23:0] sig_chars_ff;
   logic [31:0] edit_chars_ff;

   tld_pkg::state_type state_ff, state_in;
   logic [1:0]    mode_ff;
   logic [7:0]    ch_ff, ch_in;
   logic [AW:0]   len_ff, len_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [15:0]   eof_ff, eof_in;
   logic          cr_ff, cr_in;
   logic          nl_ff, nl_in;
   logic          wspace_ff, wspace_in;
   logic [AW:0]   cnt_ff, cnt_in;
   tld_pkg::result_type res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          ls_we, rq_we;
   logic [AW-1:0] ls_waddr, ls_raddr, rq_waddr, rq_raddr;
   logic [7:0]    ls_wdata, rq_wdata, ls_rdata, rq_rdata;

   tld_ram #(.Depth(BUFFER_DEPTH)) u_line (
      .clock, .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
      .raddr(ls_raddr), .rdata(ls_rdata));
   tld_ram #(.Depth(BUFFER_DEPTH)) u_queue (
      .clock, .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
      .raddr(rq_raddr), .rdata(rq_rdata));

   logic cfg_wr;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[3:2])
         tld_pkg::RegInFlags:  csr_prdata = {28'd0, in_flags_ff};
         tld_pkg::RegLocFlags: csr_prdata = {27'd0, loc_flags_ff};
         tld_pkg::RegSigChars: csr_prdata = {8'd0, sig_chars_ff};
         default:              csr_prdata = edit_chars_ff;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         in_flags_ff   <= tld_pkg::InFlagsReset;
         loc_flags_ff  <= tld_pkg::LocFlagsReset;
         sig_chars_ff  <= tld_pkg::SigCharsReset;
         edit_chars_ff <= tld_pkg::EditCharsReset;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            tld_pkg::RegInFlags:  in_flags_ff   <= csr_pwdata[3:0];
            tld_pkg::RegLocFlags: loc_flags_ff  <= csr_pwdata[4:0];
            tld_pkg::RegSigChars: sig_chars_ff  <= csr_pwdata[23:0];
            default:              edit_chars_ff <= csr_pwdata;
         endcase
      end
   end

   logic accept;
   assign req_tready = (state_ff == tld_pkg::ST_IDLE) && !rsp_valid_ff;
   assign accept = req_tvalid && req_tready;

   // pre-edit byte
   logic [7:0] c0, cx;
   logic       cr_ignore;
   always_comb begin
      c0 = in_flags_ff[0] ? {1'b0, ch_ff[6:0]} : ch_ff;
      cx = c0;
      cr_ignore = 1'b0;
      if (c0 == 8'h0D) begin
         if (in_flags_ff[1]) cr_ignore = 1'b1;
         else if (in_flags_ff[2]) cx = 8'h0A;
      end else if (c0 == 8'h0A && in_flags_ff[3]) begin
         cx = 8'h0D;
      end
   end

   logic [1:0] sig;
   always_comb begin
      sig = 2'd0;
      if (loc_flags_ff[0]) begin
         if (sig_chars_ff[7:0] != 8'd0 && sig_chars_ff[7:0] == cx) sig = 2'd1;
         else if (sig_chars_ff[15:8] != 8'd0 && sig_chars_ff[15:8] == cx) sig = 2'd2;
         else if (sig_chars_ff[23:16] != 8'd0 && sig_chars_ff[23:16] == cx) sig = 2'd3;
      end
   end
   logic m_eof, m_era, m_kill, m_wer;
   assign m_eof  = edit_chars_ff[7:0]   != 8'd0 && edit_chars_ff[7:0]   == cx;
   assign m_era  = edit_chars_ff[15:8]  != 8'd0 && edit_chars_ff[15:8]  == cx;
   assign m_kill = edit_chars_ff[23:16] != 8'd0 && edit_chars_ff[23:16] == cx;
   assign m_wer  = edit_chars_ff[31:24] != 8'd0 && edit_chars_ff[31:24] == cx;

   logic q_full;
   assign q_full = (head_ff + One) == tail_ff;

   function automatic logic [2:0] erase_echo(input logic [4:0] lf, input logic nz);
      return (nz && lf[2] && lf[3]) ? tld_pkg::EchoErase : tld_pkg::EchoNone;
   endfunction

   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff;
      len_in = len_ff; head_in = head_ff; tail_in = tail_ff; eof_in = eof_ff;
      cr_in = cr_ff; nl_in = nl_ff; idx_in = idx_ff; cnt_in = cnt_ff;
      wspace_in = wspace_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;
      ls_we = 1'b0; ls_waddr = len_ff[AW-1:0]; ls_wdata = cx; ls_raddr = idx_ff;
      rq_we = 1'b0; rq_waddr = head_ff; rq_wdata = ls_rdata; rq_raddr = tail_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         tld_pkg::ST_IDLE: begin
            if (accept) begin
               ch_in = req_tdata[9:2];
               res_in = '0;
               state_in = tld_pkg::ST_DECIDE;
            end
         end
         tld_pkg::ST_DECIDE: begin
            state_in = tld_pkg::ST_RESULT;
            if (mode_ff == tld_pkg::ModeFlush) begin
               head_in = '0; tail_in = '0; eof_in = '0; len_in = '0;
               res_in.flushed = 1'b1;
            end else if (mode_ff == tld_pkg::ModeRead) begin
               if (head_ff != tail_ff) state_in = tld_pkg::ST_READ_RD;
               else if (eof_ff != 16'd0) begin
                  eof_in = eof_ff - 16'd1;
                  res_in.read_eof = 1'b1;
               end
            end else if (mode_ff == tld_pkg::ModeRx) begin
               if (cr_ignore) begin
                  cr_in = 1'b1;
               end else if (sig != 2'd0) begin
                  if (loc_flags_ff[2]) res_in.echo_kind = tld_pkg::echo_kind_of(cx);
                  if (loc_flags_ff[2] && (res_in.echo_kind == tld_pkg::EchoByte ||
                      res_in.echo_kind == tld_pkg::EchoCaret)) res_in.echo_byte = cx;
                  if (!loc_flags_ff[4]) begin
                     head_in = '0; tail_in = '0; eof_in = '0; len_in = '0;
                     res_in.flushed = 1'b1;
                  end
                  res_in.signal_kind = sig;
               end else if (!loc_flags_ff[1]) begin
                  if (loc_flags_ff[2]) res_in.echo_kind = tld_pkg::echo_kind_of(cx);
                  if (loc_flags_ff[2] && (res_in.echo_kind == tld_pkg::EchoByte ||
                      res_in.echo_kind == tld_pkg::EchoCaret)) res_in.echo_byte = cx;
                  if (!q_full) begin
                     rq_we = 1'b1; rq_wdata = cx; head_in = head_ff + One;
                  end
                  res_in.wake = 1'b1;
                  cr_in = (cx == 8'h0D);
               end else if (cx == 8'h0D || cx == 8'h0A) begin
                  if (cx == 8'h0A && cr_ff) begin
                     cr_in = 1'b0;
                  end else begin
                     cr_in = (cx == 8'h0D);
                     if (loc_flags_ff[2]) res_in.echo_kind = tld_pkg::EchoCrlf;
                     res_in.wake = 1'b1;
                     nl_in = 1'b1; idx_in = '0;
                     state_in = tld_pkg::ST_COMMIT_RD;
                  end
               end else begin
                  cr_in = 1'b0;
                  if (m_eof) begin
                     res_in.wake = 1'b1;
                     if (len_ff == '0) begin
                        if (eof_ff != tld_pkg::EofMax) eof_in = eof_ff + 16'd1;
                     end else begin
                        nl_in = 1'b0; idx_in = '0;
                        state_in = tld_pkg::ST_COMMIT_RD;
                     end
                  end else if (m_era) begin
                     if (len_ff != '0) begin
                        len_in = len_ff - 1'b1;
                        res_in.erase_count = 9'd1;
                        res_in.echo_kind = erase_echo(loc_flags_ff, 1'b1);
                     end
                  end else if (m_kill) begin
                     len_in = '0;
                     res_in.erase_count = 9'(len_ff);
                     res_in.echo_kind = erase_echo(loc_flags_ff, len_ff != '0);
                  end else if (m_wer) begin
                     cnt_in = '0; wspace_in = 1'b1;
                     state_in = tld_pkg::ST_WERASE_RD;
                  end else if (len_ff < LineMax) begin
                     ls_we = 1'b1;
                     len_in = len_ff + 1'b1;
                     if (loc_flags_ff[2]) res_in.echo_kind = tld_pkg::echo_kind_of(cx);
                     if (loc_flags_ff[2] && (res_in.echo_kind == tld_pkg::EchoByte ||
                         res_in.echo_kind == tld_pkg::EchoCaret)) res_in.echo_byte = cx;
                  end
               end
            end
         end
         tld_pkg::ST_COMMIT_RD: begin
            if ((AW+1)'(idx_ff) == len_ff) begin
               len_in = '0;
               state_in = nl_ff ? tld_pkg::ST_COMMIT_NL : tld_pkg::ST_RESULT;
            end else begin
               state_in = tld_pkg::ST_COMMIT_WR;
            end
         end
         tld_pkg::ST_COMMIT_WR: begin
            if (!q_full) begin
               rq_we = 1'b1; head_in = head_ff + One;
            end
            idx_in = idx_ff + One;
            state_in = tld_pkg::ST_COMMIT_RD;
         end
         tld_pkg::ST_COMMIT_NL: begin
            if (!q_full) begin
               rq_we = 1'b1; rq_wdata = 8'h0A; head_in = head_ff + One;
            end
            state_in = tld_pkg::ST_RESULT;
         end
         tld_pkg::ST_WERASE_RD: begin
            if (len_ff == '0) begin
               res_in.erase_count = 9'(cnt_ff);
               res_in.echo_kind = erase_echo(loc_flags_ff, cnt_ff != '0);
               state_in = tld_pkg::ST_RESULT;
            end else begin
               ls_raddr = AW'(len_ff - 1'b1);
               state_in = tld_pkg::ST_WERASE_CHK;
            end
         end
         tld_pkg::ST_WERASE_CHK: begin
            if (wspace_ff && ls_rdata == 8'h20) begin
               len_in = len_ff - 1'b1; cnt_in = cnt_ff + 1'b1;
               state_in = tld_pkg::ST_WERASE_RD;
            end else if (ls_rdata != 8'h20) begin
               wspace_in = 1'b0;
               len_in = len_ff - 1'b1; cnt_in = cnt_ff + 1'b1;
               state_in = tld_pkg::ST_WERASE_RD;
            end else begin
               res_in.erase_count = 9'(cnt_ff);
               res_in.echo_kind = erase_echo(loc_flags_ff, cnt_ff != '0);
               state_in = tld_pkg::ST_RESULT;
            end
         end
         tld_pkg::ST_READ_RD: begin
            state_in = tld_pkg::ST_READ_DONE;
         end
         tld_pkg::ST_READ_DONE: begin
            res_in.read_valid = 1'b1;
            res_in.read_byte = rq_rdata;
            res_in.line_done = loc_flags_ff[1] && rq_rdata == 8'h0A;
            tail_in = tail_ff + One;
            state_in = tld_pkg::ST_RESULT;
         end
         tld_pkg::ST_RESULT: begin
            res_in.queue_count = 9'(head_ff - tail_ff);
            rsp_valid_in = 1'b1;
            state_in = tld_pkg::ST_IDLE;
         end
         default: state_in = tld_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tld_pkg::ST_IDLE;
         len_ff <= '0; head_ff <= '0; tail_ff <= '0; eof_ff <= '0; cr_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in; head_ff <= head_in; tail_ff <= tail_in;
         eof_ff <= eof_in; cr_ff <= cr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) mode_ff <= req_tdata[1:0];
      ch_ff <= ch_in; nl_ff <= nl_in; idx_ff <= idx_in; cnt_ff <= cnt_in;
      wspace_ff <= wspace_in; res_ff <= res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'd0, res_ff.queue_count, res_ff.line_done, res_ff.read_eof,
                       res_ff.read_byte, res_ff.read_valid, res_ff.flushed, res_ff.wake,
                       res_ff.signal_kind, res_ff.erase_count, res_ff.echo_byte,
                       res_ff.echo_kind};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_valid_ff) else $error("ready while result pending");
   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LineMax) else $error("line length overflow");
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(res_ff)) else $error("result changed");
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // mode[1:0], in_byte[9:2], zeros
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // echo_kind[2:0], echo_byte[10:3], erase_count[19:11], signal_kind[21:20],
   // wake[22], flushed[23], read_valid[24], read_byte[32:25], read_eof[33],
   // line_done[34], queue_count[43:35], zeros
   logic [47:0] rsp_tdata;

   tty_line_discipline i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model of the line discipline
   logic [3:0]  in_flags = tld_pkg::InFlagsReset;
   logic [4:0]  loc_flags = tld_pkg::LocFlagsReset;
   logic [23:0] sig_chars = tld_pkg::SigCharsReset;
   logic [31:0] edit_chars = tld_pkg::EditCharsReset;
   logic [7:0]  line_buf [tld_pkg::BufferDepth];
   logic [7:0]  read_buf [tld_pkg::BufferDepth];
   int unsigned line_len = 0;
   logic        after_cr = 1'b0;
   logic [8:0]  q_head = '0, q_tail = '0;
   logic [15:0] eof_count = '0;

   logic [9:0]  pending_items [$];   // {in_byte, mode}
   tld_pkg::result_type expected_results [$];

   int unsigned accept_count = 0, seen_count = 0;
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int unsigned tx_gap = 0, rx_gap = 0, hold_count = 0;
   bit          quiet = 1'b0;
   bit          long_hold = 1'b0;

   function automatic void clear_pending();
      q_head = '0;
      q_tail = '0;
      eof_count = '0;
      line_len = 0;
   endfunction

   function automatic void push_byte(logic [7:0] c);
      logic [8:0] nxt;
      nxt = q_head + 9'd1;
      if (nxt != q_tail) begin
         read_buf[q_head] = c;
         q_head = nxt;
      end
   endfunction

   function automatic void commit_line(bit with_nl);
      for (int i = 0; i < line_len; i++) push_byte(line_buf[i]);
      if (with_nl) push_byte(8'h0A);
      line_len = 0;
   endfunction

   function automatic logic [2:0] echo_kind_for(logic [7:0] c);
      if (c == 8'h0A || c == 8'h0D) return tld_pkg::EchoCrlf;
      if (c == 8'h09) return tld_pkg::EchoByte;
      if (c < 8'h20) return tld_pkg::EchoCaret;
      if (c == 8'h7F) return tld_pkg::EchoNone;
      return tld_pkg::EchoByte;
   endfunction

   function automatic void put_echo(inout tld_pkg::result_type r, input logic [7:0] c);
      if (!loc_flags[2]) return;
      r.echo_kind = echo_kind_for(c);
      if (r.echo_kind == tld_pkg::EchoByte || r.echo_kind == tld_pkg::EchoCaret)
         r.echo_byte = c;
   endfunction

   function automatic void erase_report(inout tld_pkg::result_type r,
                                        input int unsigned n);
      r.erase_count = n[8:0];
      if (n != 0 && loc_flags[2] && loc_flags[3]) r.echo_kind = tld_pkg::EchoErase;
   endfunction

   function automatic bit key_hit(logic [7:0] k, logic [7:0] c);
      return k != 8'h00 && k == c;
   endfunction

   function automatic tld_pkg::result_type discipline_step(logic [1:0] mode,
                                                           logic [7:0] b);
      tld_pkg::result_type r;
      logic [7:0]  c;
      bit          done;
      int unsigned n;
      r = '0;
      c = b;
      done = 1'b0;
      if (mode == tld_pkg::ModeRx) begin
         if (in_flags[0]) c = c & 8'h7F;
         if (c == 8'h0D) begin
            if (in_flags[1]) begin
               after_cr = 1'b1;
               done = 1'b1;
            end else if (in_flags[2]) c = 8'h0A;
         end else if (c == 8'h0A && in_flags[3]) c = 8'h0D;
         if (!done && loc_flags[0]) begin
            for (int i = 0; i < 3; i++) begin
               if (!done && key_hit(sig_chars[8*i +: 8], c)) begin
                  put_echo(r, c);
                  if (!loc_flags[4]) begin
                     clear_pending();
                     r.flushed = 1'b1;
                  end
                  r.signal_kind = 2'(i + 1);
                  done = 1'b1;
               end
            end
         end
         if (!done && !loc_flags[1]) begin
            put_echo(r, c);
            push_byte(c);
            r.wake = 1'b1;
            after_cr = (c == 8'h0D);
            done = 1'b1;
         end
         if (!done && (c == 8'h0D || c == 8'h0A)) begin
            if (c == 8'h0A && after_cr) after_cr = 1'b0;
            else begin
               after_cr = (c == 8'h0D);
               put_echo(r, 8'h0A);
               commit_line(1'b1);
               r.wake = 1'b1;
            end
            done = 1'b1;
         end
         if (!done) begin
            after_cr = 1'b0;
            if (key_hit(edit_chars[7:0], c)) begin
               if (line_len == 0) begin
                  if (eof_count != tld_pkg::EofMax) eof_count++;
               end else commit_line(1'b0);
               r.wake = 1'b1;
            end else if (key_hit(edit_chars[15:8], c)) begin
               if (line_len != 0) begin
                  line_len--;
                  erase_report(r, 1);
               end
            end else if (key_hit(edit_chars[23:16], c)) begin
               n = line_len;
               line_len = 0;
               erase_report(r, n);
            end else if (key_hit(edit_chars[31:24], c)) begin
               n = 0;
               while (line_len != 0 && line_buf[line_len-1] == 8'h20) begin
                  line_len--;
                  n++;
               end
               while (line_len != 0 && line_buf[line_len-1] != 8'h20) begin
                  line_len--;
                  n++;
               end
               erase_report(r, n);
            end else if (line_len < tld_pkg::BufferDepth - 1) begin
               line_buf[line_len] = c;
               line_len++;
               put_echo(r, c);
            end
         end
      end else if (mode == tld_pkg::ModeRead) begin
         if (q_head != q_tail) begin
            r.read_valid = 1'b1;
            r.read_byte = read_buf[q_tail];
            q_tail = q_tail + 9'd1;
            if (loc_flags[1] && r.read_byte == 8'h0A) r.line_done = 1'b1;
         end else if (eof_count != 0) begin
            eof_count--;
            r.read_eof = 1'b1;
         end
      end else if (mode == tld_pkg::ModeFlush) begin
         clear_pending();
         r.flushed = 1'b1;
      end
      r.queue_count = q_head - q_tail;
      return r;
   endfunction

   // sender
   always @(negedge clock) begin
      if (!reset && !(req_tvalid && accept_count == seen_count)) begin
         seen_count = accept_count;
         if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(0, 4);
            req_tvalid <= 1'b0;
         end else begin
            req_tdata <= {6'b0, pending_items.pop_front()};
            req_tvalid <= 1'b1;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (long_hold && hold_count < 400) begin
         hold_count++;
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rx_gap = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   // input transfers feed the model, output transfers are checked
   always @(posedge clock) begin
      tld_pkg::result_type got, want;
      cycles++;
      if (!reset && req_tvalid && req_tready) begin
         accept_count++;
         expected_results.push_back(discipline_step(req_tdata[1:0], req_tdata[9:2]));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.echo_kind = rsp_tdata[2:0];
         got.echo_byte = rsp_tdata[10:3];
         got.erase_count = rsp_tdata[19:11];
         got.signal_kind = rsp_tdata[21:20];
         got.wake = rsp_tdata[22];
         got.flushed = rsp_tdata[23];
         got.read_valid = rsp_tdata[24];
         got.read_byte = rsp_tdata[32:25];
         got.read_eof = rsp_tdata[33];
         got.line_done = rsp_tdata[34];
         got.queue_count = rsp_tdata[43:35];
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("expected %p\n  actual %p", want, got);
            end
         end
      end
      if (cycles > 3000000) begin
         $display("tty_line_discipline: mismatch");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         tld_pkg::RegInFlags:   in_flags = value[3:0];
         tld_pkg::RegLocFlags:  loc_flags = value[4:0];
         tld_pkg::RegSigChars:  sig_chars = value[23:0];
         default:               edit_chars = value;
      endcase
   endtask

   task automatic configure(logic [3:0] inf, logic [4:0] lf, logic [23:0] sc,
                            logic [31:0] ec);
      csr_write(tld_pkg::RegInFlags, {28'b0, inf});
      csr_write(tld_pkg::RegLocFlags, {27'b0, lf});
      csr_write(tld_pkg::RegSigChars, {8'b0, sc});
      csr_write(tld_pkg::RegEditChars, ec);
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic add(logic [1:0] mode, logic [7:0] b);
      pending_items.push_back({b, mode});
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return sig_chars[8*$urandom_range(0, 2) +: 8];
         1, 2: return edit_chars[8*$urandom_range(0, 3) +: 8];
         3: return $urandom_range(0, 1) ? 8'h0D : 8'h0A;
         4: return 8'h20;
         5, 6: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h21, 8'h7E));
      endcase
   endfunction

   task automatic random_items(int unsigned count);
      int unsigned sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 62) add(tld_pkg::ModeRx, pick_byte());
         else if (sel < 95) add(tld_pkg::ModeRead, 8'($urandom_range(0, 255)));
         else if (sel < 98) add(tld_pkg::ModeFlush, 8'($urandom_range(0, 255)));
         else add(2'd3, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults: canonical, echo, signals
      add(tld_pkg::ModeRx, "a"); add(tld_pkg::ModeRx, "b");
      add(tld_pkg::ModeRx, 8'h7F); add(tld_pkg::ModeRx, "w");
      add(tld_pkg::ModeRx, " "); add(tld_pkg::ModeRx, "x");
      add(tld_pkg::ModeRx, 8'h17); add(tld_pkg::ModeRx, 8'h15);
      add(tld_pkg::ModeRx, 8'h15); add(tld_pkg::ModeRx, 8'h7F);
      add(tld_pkg::ModeRx, 8'h09); add(tld_pkg::ModeRx, 8'hFF);
      add(tld_pkg::ModeRx, 8'h00); add(tld_pkg::ModeRx, 8'h0D);
      add(tld_pkg::ModeRx, 8'h0A); add(tld_pkg::ModeRead, 8'h00);
      add(tld_pkg::ModeRead, 8'h00); add(tld_pkg::ModeRead, 8'h00);
      add(tld_pkg::ModeRead, 8'h00);
      add(tld_pkg::ModeRx, 8'h04); add(tld_pkg::ModeRead, 8'hFF);
      add(tld_pkg::ModeRx, 8'h03);
      add(2'd3, 8'hAA); add(tld_pkg::ModeFlush, 8'h55);
      drain();

      // ignore CR, strip, no-flush signals
      configure(4'b1011, 5'b11111, tld_pkg::SigCharsReset, tld_pkg::EditCharsReset);
      add(tld_pkg::ModeRx, 8'h8D); add(tld_pkg::ModeRx, 8'h0A);
      add(tld_pkg::ModeRx, "q"); add(tld_pkg::ModeRx, 8'h0A);
      add(tld_pkg::ModeRx, 8'h83); add(tld_pkg::ModeRead, 8'h00);
      add(tld_pkg::ModeRead, 8'h00);
      drain();

      // fill the line store and the read queue while the receiver holds off
      configure(4'h0, 5'b00110, 24'h0, tld_pkg::EditCharsReset);
      long_hold = 1'b1;
      for (int i = 0; i < 515; i++) add(tld_pkg::ModeRx, 8'($urandom_range(8'h20, 8'h7E)));
      add(tld_pkg::ModeRx, 8'h0A); add(tld_pkg::ModeRx, 8'h04);
      add(tld_pkg::ModeRx, "z"); add(tld_pkg::ModeRx, 8'h04);
      for (int i = 0; i < 6; i++) add(tld_pkg::ModeRead, 8'h00);
      add(tld_pkg::ModeFlush, 8'h00);
      drain();

      configure(4'h0, 5'h00, 24'h0, 32'h0);
      random_items(30);
      drain();
      configure(4'hF, 5'h1F, 24'hFFFFFF, 32'hFFFFFFFF);
      random_items(30);
      drain();
      for (int p = 0; p < 4; p++) begin
         configure(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                   24'($urandom()), 32'($urandom()));
         random_items(15);
         drain();
      end
      configure(tld_pkg::InFlagsReset, tld_pkg::LocFlagsReset,
                tld_pkg::SigCharsReset, tld_pkg::EditCharsReset);
      quiet = 1'b1;
      random_items(30);
      drain();

      if (mismatches == 0 && expected_results.size() == 0)
         $display("tty_line_discipline: match");
      else
         $display("tty_line_discipline: mismatch");
      $finish;
   end
endmodule
